// ===== design/vtc_pkg.sv =====
`default_nettype none
package vtc_pkg;
  localparam int NCOEF = 28;
  localparam logic [31:0] ONE_Q = 32'h0001_0000;

  typedef logic signed [31:0] q_t;

  typedef struct packed {
    q_t pos_x;
    q_t pos_y;
    q_t pos_z;
    q_t nrm_x;
    q_t nrm_y;
    q_t nrm_z;
  } vtx_t;

  typedef struct packed {
    q_t scr_x;
    q_t scr_y;
    q_t scr_z;
    q_t scr_w;
    q_t world_x;
    q_t world_y;
    q_t world_z;
    q_t out_nrm_x;
    q_t out_nrm_y;
    q_t out_nrm_z;
  } vdata_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MODEL, ST_CLIP, ST_DIV, ST_DONE
  } be_state_t;

  function automatic q_t sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] coef_reset(input logic [4:0] idx);
    logic [31:0] r;
    r = '0;
    unique case (idx)
      5'd0, 5'd5, 5'd10, 5'd12, 5'd17, 5'd22, 5'd27: r = ONE_Q;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== design/vtc_if.sv =====
`default_nettype none
interface vtc_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [4:0]  coef_index;
  logic [31:0] coef_value;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [31:0] nrm_x;
  logic [31:0] nrm_y;
  logic [31:0] nrm_z;
  modport source(output valid, mode, coef_index, coef_value, pos_x, pos_y, pos_z,
                 nrm_x, nrm_y, nrm_z, input ready);
  modport sink(input valid, mode, coef_index, coef_value, pos_x, pos_y, pos_z,
               nrm_x, nrm_y, nrm_z, output ready);
endinterface

interface vtc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] scr_x;
  logic [31:0] scr_y;
  logic [31:0] scr_z;
  logic [31:0] scr_w;
  logic [31:0] world_x;
  logic [31:0] world_y;
  logic [31:0] world_z;
  logic [31:0] out_nrm_x;
  logic [31:0] out_nrm_y;
  logic [31:0] out_nrm_z;
  logic        tri_end;
  modport source(output valid, scr_x, scr_y, scr_z, scr_w, world_x, world_y, world_z,
                 out_nrm_x, out_nrm_y, out_nrm_z, tri_end, input ready);
  modport sink(input valid, scr_x, scr_y, scr_z, scr_w, world_x, world_y, world_z,
               out_nrm_x, out_nrm_y, out_nrm_z, tri_end, output ready);
endinterface
`default_nettype wire

// ===== design/vertex_transform_clip.sv =====
`default_nettype none
// channel  dir  payload
// in       in   mode, coef_index, coef_value, pos_x..z, nrm_x..z
// out      out  scr_x..w, world_x..z, out_nrm_x..z, tri_end
// a load beat is accepted only once the vertex path is empty
// a vertex passes 10 matrix rows through one shared multiply-accumulate,
// then a bit-serial divide by w and a hand-off to the output
// the third vertex of a kept triangle adds three output beats, each held until ready
// a two-entry queue between front and back lets input run ahead
// rst is synchronous; the coefficient store resets to identity
module vertex_transform_clip (
  input wire logic clk,
  input wire logic rst,
  vtc_in_if.sink    in_ch,
  vtc_out_if.source out_ch
);
  vtc_pkg::vtx_t q_vtx;
  logic          q_valid, q_pop, be_busy;
  logic [31:0]   coef [vtc_pkg::NCOEF];

  vtc_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch), .q_vtx(q_vtx), .q_valid(q_valid),
    .q_pop(q_pop), .be_busy(be_busy), .coef(coef)
  );

  vtc_back u_back (
    .clk(clk), .rst(rst), .q_vtx(q_vtx), .q_valid(q_valid), .q_pop(q_pop),
    .be_busy(be_busy), .coef(coef), .out_ch(out_ch)
  );

  // a pop only happens with a queued vertex
  a_pop: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  // a load is never accepted while the back end works
  a_load: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && !in_ch.mode) |-> !be_busy && !q_valid)
    else $error("load during vertex work");
endmodule
`default_nettype wire

// ===== design/vtc_front.sv =====
`default_nettype none
// accepts beats, writes the coefficient store, queues vertices (2 deep)
module vtc_front (
  input  wire logic          clk,
  input  wire logic          rst,
  vtc_in_if.sink             in_ch,
  output vtc_pkg::vtx_t      q_vtx,
  output logic               q_valid,
  input  wire logic          q_pop,
  input  wire logic          be_busy,
  output logic [31:0]        coef [vtc_pkg::NCOEF]
);
  vtc_pkg::vtx_t fifo [2];
  logic        wp, rp;
  logic [1:0]  cnt;
  logic        acc, push;

  // loads wait until no vertex is queued or in flight so order is kept
  assign in_ch.ready = in_ch.mode ? (cnt != 2'd2) : (cnt == 2'd0 && !be_busy);
  assign acc  = in_ch.valid && in_ch.ready;
  assign push = acc && in_ch.mode;
  assign q_valid = cnt != 2'd0;
  assign q_vtx = fifo[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= '0;
      for (int i = 0; i < vtc_pkg::NCOEF; i++) begin
        coef[i] <= vtc_pkg::coef_reset(5'(i));
      end
    end else begin
      if (acc && !in_ch.mode && in_ch.coef_index < 5'(vtc_pkg::NCOEF))
        coef[in_ch.coef_index] <= in_ch.coef_value;
      if (push) begin
        fifo[wp] <= '{in_ch.pos_x, in_ch.pos_y, in_ch.pos_z,
                      in_ch.nrm_x, in_ch.nrm_y, in_ch.nrm_z};
        wp <= ~wp;
      end
      if (q_pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

// ===== design/vtc_div.sv =====
`default_nettype none
// restoring divider, one quotient bit per cycle, (n << 16) / d toward zero
module vtc_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] num,
  input  wire logic signed [31:0] den,
  output logic                    done,
  output logic signed [48:0]      quo
);
  logic [47:0] n_mag, q;
  logic [31:0] d_mag;
  logic [32:0] rem;
  logic [33:0] trial;
  logic [5:0]  bitn;
  logic        neg, busy;

  assign trial = {rem, n_mag[47]} - {2'b0, d_mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        n_mag <= {(num[31] ? 32'(-num) : 32'(num)), 16'h0};
        d_mag <= den[31] ? 32'(-den) : 32'(den);
        neg   <= num[31] ^ den[31];
        rem   <= '0;
        q     <= '0;
        bitn  <= 6'd48;
        busy  <= 1'b1;
      end else if (busy) begin
        if (!trial[33]) begin
          rem <= trial[32:0];
          q   <= {q[46:0], 1'b1};
        end else begin
          rem <= {rem[31:0], n_mag[47]};
          q   <= {q[46:0], 1'b0};
        end
        n_mag <= {n_mag[46:0], 1'b0};
        bitn <= bitn - 6'd1;
        if (bitn == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign quo = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
endmodule
`default_nettype wire

// ===== design/vtc_back.sv =====
`default_nettype none
// one multiplier, one term a cycle while a row issues; three dividers; triangle grouping
module vtc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire vtc_pkg::vtx_t q_vtx,
  input  wire logic          q_valid,
  output logic               q_pop,
  output logic               be_busy,
  input  wire logic [31:0]   coef [vtc_pkg::NCOEF],
  vtc_out_if.source          out_ch
);
  localparam logic signed [31:0] ONE_Q_S = vtc_pkg::ONE_Q;

  vtc_pkg::be_state_t state, state_next;
  logic [4:0]  row;
  logic [1:0]  term;
  logic signed [65:0] acc, acc_sh;
  logic signed [63:0] prod;
  logic signed [31:0] ca, va;
  logic signed [31:0] res [10];
  vtc_pkg::vdata_t buf0, buf1, cur;
  logic [1:0]  slot;
  logic        rej, div_start, dbad;
  logic [2:0]  div_done;
  logic signed [48:0] quo [3];
  logic [1:0]  emit;
  logic        out_load;
  logic signed [31:0] vin;
  logic [4:0]  cidx;

  // rows 0-2 world, 3-5 normal, 6-9 clip
  always_comb begin
    vin = '0;
    cidx = '0;
    if (row < 5'd3) begin
      cidx = 5'(row * 4 + term);
      unique case (term)
        2'd0: vin = q_vtx.pos_x;
        2'd1: vin = q_vtx.pos_y;
        2'd2: vin = q_vtx.pos_z;
        default: vin = ONE_Q_S;
      endcase
    end else if (row < 5'd6) begin
      cidx = 5'((row - 5'd3) * 4 + term);
      unique case (term)
        2'd0: vin = q_vtx.nrm_x;
        2'd1: vin = q_vtx.nrm_y;
        2'd2: vin = q_vtx.nrm_z;
        default: vin = '0;
      endcase
    end else begin
      cidx = 5'(12 + (row - 5'd6) * 4 + term);
      unique case (term)
        2'd0: vin = res[0];
        2'd1: vin = res[1];
        2'd2: vin = res[2];
        default: vin = ONE_Q_S;
      endcase
    end
  end

  // exact floor of the full sum equals arithmetic shift of the summed products
  // two guard bits keep four full-range products from wrapping
  assign prod = ca * va;
  assign acc_sh = acc >>> 16;

  always_comb begin
    state_next = state;
    unique case (state)
      vtc_pkg::ST_IDLE:  if (q_valid) state_next = vtc_pkg::ST_MODEL;
      vtc_pkg::ST_MODEL: if (row == 5'd6) state_next = vtc_pkg::ST_CLIP;
      vtc_pkg::ST_CLIP:  if (row == 5'd10) state_next = vtc_pkg::ST_DIV;
      vtc_pkg::ST_DIV:   if (&div_done) state_next = vtc_pkg::ST_DONE;
      vtc_pkg::ST_DONE:  if (emit == 2'd0) state_next = vtc_pkg::ST_IDLE;
      default:           state_next = vtc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    be_busy = state != vtc_pkg::ST_IDLE;
    if (state == vtc_pkg::ST_DONE && emit == 2'd0) q_pop = 1'b1;
  end

  // output register takes the next beat when empty or being drained
  assign out_load = state == vtc_pkg::ST_DONE && emit != 2'd0 &&
                    (!out_ch.valid || out_ch.ready);

  // mac: register operands, then accumulate; a row is stored after its 4 terms and a drain step
  logic [2:0] phase;
  logic       mac_on;
  assign mac_on = state == vtc_pkg::ST_MODEL || state == vtc_pkg::ST_CLIP;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vtc_pkg::ST_IDLE;
      row <= '0;
      term <= '0;
      phase <= '0;
      slot <= '0;
      rej <= 1'b0;
      emit <= '0;
      out_ch.valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      state <= state_next;
      div_start <= state == vtc_pkg::ST_CLIP && state_next == vtc_pkg::ST_DIV;
      if (out_load) out_ch.valid <= 1'b1;
      else if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      if (state == vtc_pkg::ST_IDLE) begin
        row <= '0;
        term <= '0;
        phase <= '0;
      end
      if (mac_on && row != 5'd10 && !(state == vtc_pkg::ST_MODEL && row == 5'd6)) begin
        // phase 0..3 issue terms, 4 drains last product, 5 stores row
        if (phase < 3'd4) begin
          ca <= coef[cidx];
          va <= vin;
          term <= term + 2'd1;
        end
        if (phase == 3'd0) acc <= '0;
        else if (phase < 3'd5) acc <= acc + 66'(prod);
        if (phase == 3'd5) begin
          res[row[3:0]] <= vtc_pkg::sat32(acc_sh[63:0]);
          row <= row + 5'd1;
          phase <= '0;
          term <= '0;
        end else phase <= phase + 3'd1;
      end
      if (state == vtc_pkg::ST_DIV && (&div_done)) begin
        cur.scr_w <= res[9];
        cur.world_x <= res[0];
        cur.world_y <= res[1];
        cur.world_z <= res[2];
        cur.out_nrm_x <= res[3];
        cur.out_nrm_y <= res[4];
        cur.out_nrm_z <= res[5];
        cur.scr_x <= (res[9] == 0) ? '0 : vtc_pkg::sat32(64'(quo[0]));
        cur.scr_y <= (res[9] == 0) ? '0 : vtc_pkg::sat32(64'(quo[1]));
        cur.scr_z <= (res[9] == 0) ? '0 : vtc_pkg::sat32(64'(quo[2]));
        if (slot != 2'd2) emit <= '0;
        else emit <= (dbad || rej) ? 2'd0 : 2'd3;
      end
      if (state == vtc_pkg::ST_DONE) begin
        if (slot == 2'd0 && emit == 2'd0) begin
          buf0 <= cur;
          slot <= 2'd1;
          rej <= rej | dbad;
        end else if (slot == 2'd1 && emit == 2'd0) begin
          buf1 <= cur;
          slot <= 2'd2;
          rej <= rej | dbad;
        end else if (emit == 2'd0) begin
          slot <= '0;
          rej <= 1'b0;
        end else if (out_load) begin
          {out_ch.scr_x, out_ch.scr_y, out_ch.scr_z, out_ch.scr_w, out_ch.world_x,
           out_ch.world_y, out_ch.world_z, out_ch.out_nrm_x, out_ch.out_nrm_y,
           out_ch.out_nrm_z} <= (emit == 2'd3) ? buf0 : (emit == 2'd2) ? buf1 : cur;
          out_ch.tri_end <= emit == 2'd1;
          emit <= emit - 2'd1;
        end
      end
    end
  end

  // depth test on the exact quotient
  assign dbad = (res[9] == 0) || quo[2] > 49'sd65536 || quo[2] < -49'sd65536;

  for (genvar g = 0; g < 3; g++) begin : g_div
    vtc_div u_div (
      .clk(clk), .rst(rst), .start(div_start), .num(res[6 + g]), .den(res[9]),
      .done(div_done[g]), .quo(quo[g])
    );
  end
endmodule
`default_nettype wire

// ===== bench/tb_vertex_transform_clip.sv =====
`default_nettype none
module tb_vertex_transform_clip;

  // item kinds on the input channel
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_VERTEX = 1'b1;

  // coefficient store addresses that the directed part touches
  localparam logic [4:0] IDX_M_XX   = 5'd0;   // model row 0, column 0
  localparam logic [4:0] IDX_M_ZT   = 5'd11;  // model row 2, translation
  localparam logic [4:0] IDX_VP_W0  = 5'd24;  // first entry of the w row
  localparam logic [4:0] IDX_VP_WW  = 5'd27;  // last entry of the w row
  localparam logic [4:0] IDX_UNUSED = 5'd31;  // beyond the store, ignored

  localparam vtc_pkg::q_t Q_MAX = 32'sh7fff_ffff;
  localparam vtc_pkg::q_t Q_MIN = 32'sh8000_0000;
  localparam vtc_pkg::q_t Q_ONE = 32'sh0001_0000;

  typedef struct {
    logic            mode;
    logic [4:0]      idx;
    vtc_pkg::q_t     val;
    vtc_pkg::vtx_t   vtx;
    bit              typed;  // expectation written into the table below
    vtc_pkg::vdata_t want;
  } in_beat_t;

  typedef struct packed {
    vtc_pkg::vdata_t d;
    logic            last;
  } vert_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  vtc_in_if  in_ch();
  vtc_out_if out_ch();

  vertex_transform_clip u_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // predictor state: coefficients and the partial triangle
  vtc_pkg::q_t     coef_mem[vtc_pkg::NCOEF];
  int              tri_count;
  bit              tri_bad;
  vtc_pkg::vdata_t held[2];

  vert_out_t pending_verts[$];
  in_beat_t  plan[$];
  int        fail_count = 0;
  int        idle_in = 0;
  int        idle_out = 0;

  // one matrix row times a 4-vector, floored after the fixed-point shift
  function automatic vtc_pkg::q_t mat_row(input int base, input vtc_pkg::q_t v0,
                                          input vtc_pkg::q_t v1, input vtc_pkg::q_t v2,
                                          input vtc_pkg::q_t v3);
    logic signed [79:0] acc, a, b;
    vtc_pkg::q_t v[4];
    v = '{v0, v1, v2, v3};
    acc = '0;
    for (int k = 0; k < 4; k++) begin
      a = coef_mem[base + k];
      b = v[k];
      acc = acc + a * b;
    end
    acc = acc >>> 16;
    if (acc > 80'sd2147483647) return Q_MAX;
    if (acc < -80'sd2147483648) return Q_MIN;
    return acc[31:0];
  endfunction

  function automatic vtc_pkg::q_t sat_q(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return Q_MAX;
    if (v < -64'sd2147483648) return Q_MIN;
    return v[31:0];
  endfunction

  // append one expected result beat
  function automatic void expect_result(input vtc_pkg::vdata_t d, input logic last);
    vert_out_t e;
    e.d = d;
    e.last = last;
    pending_verts = {pending_verts, e};
  endfunction

  // append one row to the stimulus table
  function automatic void add_row(input in_beat_t b);
    plan = {plan, b};
  endfunction

  // advance the triangle model by one accepted beat
  function automatic void transform_vertex(input in_beat_t b);
    vtc_pkg::vdata_t d;
    bit bad;
    logic signed [63:0] num, den, qz, qx, qy;
    if (b.mode == MODE_LOAD) begin
      if (b.idx < vtc_pkg::NCOEF) coef_mem[b.idx] = b.val;
      return;
    end
    d.world_x   = mat_row(0, b.vtx.pos_x, b.vtx.pos_y, b.vtx.pos_z, Q_ONE);
    d.world_y   = mat_row(4, b.vtx.pos_x, b.vtx.pos_y, b.vtx.pos_z, Q_ONE);
    d.world_z   = mat_row(8, b.vtx.pos_x, b.vtx.pos_y, b.vtx.pos_z, Q_ONE);
    d.out_nrm_x = mat_row(0, b.vtx.nrm_x, b.vtx.nrm_y, b.vtx.nrm_z, '0);
    d.out_nrm_y = mat_row(4, b.vtx.nrm_x, b.vtx.nrm_y, b.vtx.nrm_z, '0);
    d.out_nrm_z = mat_row(8, b.vtx.nrm_x, b.vtx.nrm_y, b.vtx.nrm_z, '0);
    d.scr_x = mat_row(12, d.world_x, d.world_y, d.world_z, Q_ONE);
    d.scr_y = mat_row(16, d.world_x, d.world_y, d.world_z, Q_ONE);
    d.scr_z = mat_row(20, d.world_x, d.world_y, d.world_z, Q_ONE);
    d.scr_w = mat_row(24, d.world_x, d.world_y, d.world_z, Q_ONE);
    bad = 1'b0;
    if (d.scr_w == 0) begin
      d.scr_x = '0;
      d.scr_y = '0;
      d.scr_z = '0;
      bad = 1'b1;
    end else begin
      den = d.scr_w;
      num = d.scr_x; qx = (num <<< 16) / den;
      num = d.scr_y; qy = (num <<< 16) / den;
      num = d.scr_z; qz = (num <<< 16) / den;
      if (qz > 64'sd65536 || qz < -64'sd65536) bad = 1'b1;
      d.scr_x = sat_q(qx);
      d.scr_y = sat_q(qy);
      d.scr_z = sat_q(qz);
    end
    if (b.typed) d = b.want;
    if (tri_count < 2) begin
      held[tri_count] = d;
      if (bad) tri_bad = 1'b1;
      tri_count++;
      return;
    end
    if (!bad && !tri_bad) begin
      expect_result(held[0], 1'b0);
      expect_result(held[1], 1'b0);
      expect_result(d, 1'b1);
    end
    tri_count = 0;
    tri_bad = 1'b0;
  endfunction

  // drive one beat, honoring the sender idle rate, then feed the predictor
  task automatic send_beat(input in_beat_t b);
    while ($urandom_range(99) < idle_in) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= b.mode;
    in_ch.coef_index <= b.idx;
    in_ch.coef_value <= b.val;
    in_ch.pos_x      <= b.vtx.pos_x;
    in_ch.pos_y      <= b.vtx.pos_y;
    in_ch.pos_z      <= b.vtx.pos_z;
    in_ch.nrm_x      <= b.vtx.nrm_x;
    in_ch.nrm_y      <= b.vtx.nrm_y;
    in_ch.nrm_z      <= b.vtx.nrm_z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    transform_vertex(b);
  endtask

  function automatic in_beat_t load_beat(input logic [4:0] idx, input vtc_pkg::q_t val);
    in_beat_t b;
    b = '{default: '0};
    b.mode = MODE_LOAD;
    b.idx  = idx;
    b.val  = val;
    return b;
  endfunction

  function automatic in_beat_t vert_beat(input vtc_pkg::q_t px, input vtc_pkg::q_t py,
                                         input vtc_pkg::q_t pz, input vtc_pkg::q_t nx,
                                         input vtc_pkg::q_t ny, input vtc_pkg::q_t nz);
    in_beat_t b;
    b = '{default: '0};
    b.mode = MODE_VERTEX;
    b.vtx  = '{px, py, pz, nx, ny, nz};
    return b;
  endfunction

  // vertex with identity matrices: everything passes straight through, w = 1.0
  function automatic in_beat_t ident_beat(input vtc_pkg::q_t px, input vtc_pkg::q_t py,
                                          input vtc_pkg::q_t pz, input vtc_pkg::q_t nx,
                                          input vtc_pkg::q_t ny, input vtc_pkg::q_t nz);
    in_beat_t b;
    b = vert_beat(px, py, pz, nx, ny, nz);
    b.typed = 1'b1;
    b.want  = '{px, py, pz, Q_ONE, px, py, pz, nx, ny, nz};
    return b;
  endfunction

  // random content: mostly small coordinates so that many triangles survive
  function automatic in_beat_t rand_beat();
    in_beat_t b;
    vtc_pkg::q_t r[6];
    if ($urandom_range(99) < 12) begin
      if ($urandom_range(9) == 0) return load_beat(5'($urandom_range(31)), $urandom);
      return load_beat(5'($urandom_range(31)),
                       32'($signed($urandom_range(98304)) - 49152));
    end
    for (int k = 0; k < 6; k++) r[k] = $urandom;
    if ($urandom_range(99) < 85) begin
      r[0] = 32'($signed($urandom_range(262144)) - 131072);
      r[1] = 32'($signed($urandom_range(262144)) - 131072);
      r[2] = 32'($signed($urandom_range(65536)) - 32768);
      if ($urandom_range(1)) begin
        r[3] = 32'($signed($urandom_range(131072)) - 65536);
        r[4] = 32'($signed($urandom_range(131072)) - 65536);
        r[5] = 32'($signed($urandom_range(131072)) - 65536);
      end
    end
    b = vert_beat(r[0], r[1], r[2], r[3], r[4], r[5]);
    return b;
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_verts.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s expected %h actual %h", name, want, got);
      fail_count++;
    end
  endtask

  // result side: random stalls, every accepted beat checked in order
  always @(posedge clk) begin
    vert_out_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_verts.size() == 0) begin
        $error("result beat with nothing expected");
        fail_count++;
      end else begin
        e = pending_verts.pop_front();
        check_field("scr_x", e.d.scr_x, out_ch.scr_x);
        check_field("scr_y", e.d.scr_y, out_ch.scr_y);
        check_field("scr_z", e.d.scr_z, out_ch.scr_z);
        check_field("scr_w", e.d.scr_w, out_ch.scr_w);
        check_field("world_x", e.d.world_x, out_ch.world_x);
        check_field("world_y", e.d.world_y, out_ch.world_y);
        check_field("world_z", e.d.world_z, out_ch.world_z);
        check_field("out_nrm_x", e.d.out_nrm_x, out_ch.out_nrm_x);
        check_field("out_nrm_y", e.d.out_nrm_y, out_ch.out_nrm_y);
        check_field("out_nrm_z", e.d.out_nrm_z, out_ch.out_nrm_z);
        check_field("tri_end", {31'b0, e.last}, {31'b0, out_ch.tri_end});
      end
    end
    out_ch.ready <= ($urandom_range(99) >= idle_out);
  end

  // hard stop in case the block hangs
  initial begin
    #1000000;
    $display("tb_vertex_transform_clip NOT OK");
    $finish;
  end

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.mode       = MODE_LOAD;
    in_ch.coef_index = '0;
    in_ch.coef_value = '0;
    in_ch.pos_x      = '0;
    in_ch.pos_y      = '0;
    in_ch.pos_z      = '0;
    in_ch.nrm_x      = '0;
    in_ch.nrm_y      = '0;
    in_ch.nrm_z      = '0;
    out_ch.ready     = 1'b0;

    // predictor reset: identity matrices, no partial triangle
    for (int i = 0; i < vtc_pkg::NCOEF; i++) coef_mem[i] = '0;
    for (int r = 0; r < 3; r++) coef_mem[r * 4 + r] = Q_ONE;
    for (int r = 0; r < 4; r++) coef_mem[12 + r * 5] = Q_ONE;
    tri_count = 0;
    tri_bad   = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    // identity after reset, depth at the limits of the unit range
    add_row(ident_beat(32'sh0001_0000, 32'sh0002_0000, 32'sh0000_8000,
                       Q_ONE, '0, '0));
    add_row(ident_beat(-32'sh0003_0000, 32'sh0000_0001, Q_ONE,
                       Q_MAX, Q_MIN, 32'sh0000_0001));
    add_row(ident_beat('0, -32'sh0000_0001, -Q_ONE, '0, '0, Q_MIN));
    // depth beyond 1.0 on the last vertex kills the triangle
    add_row(vert_beat(Q_ONE, Q_ONE, '0, '0, '0, '0));
    add_row(vert_beat(Q_ONE, '0, '0, '0, Q_ONE, '0));
    add_row(vert_beat('0, Q_ONE, 32'sh0002_0000, '0, '0, Q_ONE));
    // a load past the end of the store is dropped
    add_row(load_beat(IDX_UNUSED, Q_MAX));
    // extreme coefficients and positions drive saturation everywhere
    add_row(load_beat(IDX_M_XX, Q_MAX));
    add_row(load_beat(IDX_M_ZT, Q_MIN));
    add_row(vert_beat(Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MAX));
    add_row(vert_beat(Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN));
    add_row(vert_beat(Q_ONE, '0, Q_MAX, Q_ONE, '0, '0));
    add_row(load_beat(IDX_M_XX, Q_ONE));
    add_row(load_beat(IDX_M_ZT, '0));
    // zero w: first vertex rejected, the rest of the triangle is fine
    add_row(load_beat(IDX_VP_WW, '0));
    add_row(vert_beat(Q_ONE, Q_ONE, '0, Q_ONE, '0, '0));
    add_row(load_beat(IDX_VP_WW, Q_ONE));
    add_row(vert_beat('0, Q_ONE, '0, '0, Q_ONE, '0));
    add_row(vert_beat(Q_ONE, '0, '0, '0, '0, Q_ONE));
    // w made to depend on x through the w row, an ordinary kept triangle
    add_row(load_beat(IDX_VP_W0, 32'sh0000_8000));
    add_row(vert_beat(32'sh0002_0000, Q_ONE, 32'sh0000_4000, '0, '0, Q_ONE));
    add_row(vert_beat(-Q_ONE, Q_ONE, '0, Q_ONE, Q_ONE, '0));
    add_row(vert_beat('0, '0, -32'sh0000_8000, '0, Q_ONE, '0));
    add_row(load_beat(IDX_VP_W0, '0));
    foreach (plan[i]) send_beat(plan[i]);

    // receiver idles first, then the sender, then neither
    for (int phase = 0; phase < 3; phase++) begin
      idle_in  = (phase == 0) ? 24 : (phase == 1) ? 82 : 0;
      idle_out = (phase == 0) ? 82 : (phase == 1) ? 24 : 0;
      wait_drained();
      for (int n = 0; n < 36; n++) send_beat(rand_beat());
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_verts.size() == 0) begin
      $display("tb_vertex_transform_clip OK");
    end else begin
      $display("tb_vertex_transform_clip NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire
